// ----- design/slfa_pkg.sv -----
// slfa_pkg: shared types and constants for the slab free-list allocator
// no dependencies; used by slfa_ctrl and slab_free_list_allocator_unit
`timescale 1ns / 1ps
`default_nettype none

package slfa_pkg;

	localparam int SLAB_SLOTS   = 64;
	localparam int MAX_SLABS    = 16;
	localparam int SLOT_SPACE   = 1024;
	localparam int SLOT_W       = $clog2(SLOT_SPACE);
	localparam int CAP_W        = $clog2(SLOT_SPACE + 1);
	localparam int LIVE_W       = CAP_W;
	localparam int SLAB_CNT_W   = $clog2(MAX_SLABS + 1);
	localparam int OBJ_W        = 13;
	localparam int OFS_W        = 22;
	localparam int MIN_OBJ      = 8;
	localparam int MAX_OBJ      = 4096;
	localparam int SLABS_IN_SPACE = SLOT_SPACE / SLAB_SLOTS;
	localparam int USABLE_SLABS =
		(MAX_SLABS < SLABS_IN_SPACE) ? MAX_SLABS : SLABS_IN_SPACE;
	localparam int MAX_CAP      = USABLE_SLABS * SLAB_SLOTS;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_RESET = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// one link memory word: last marks the tail of the free list
	typedef struct packed {
		logic              last;
		logic [SLOT_W-1:0] link;
	} link_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted;
		logic [OFS_W-1:0]  offset;
		status_t           status;
		logic [LIVE_W-1:0] live;
		logic [CAP_W-1:0]  cap;
	} result_t;

endpackage

`default_nettype wire

// ----- design/slfa_link_ram.sv -----
// slfa_link_ram: generic single-write, single-read synchronous RAM
// read data registered; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module slfa_link_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/slfa_ctrl.sv -----
// slfa_ctrl: allocator sequencer; head, live count, slab count and slab fill sweep
// depends on slfa_pkg; drives the link memory and hands results to the output stage
`timescale 1ns / 1ps
`default_nettype none

module slfa_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      operation,
	input  wire logic [slfa_pkg::SLOT_W-1:0]     slot,
	input  wire logic [slfa_pkg::OBJ_W-1:0]      obj_bytes,
	input  wire logic                            out_free,
	output logic                                 done,
	output slfa_pkg::result_t                    res,
	output logic                                 ram_we,
	output logic [slfa_pkg::SLOT_W-1:0]          ram_waddr,
	output slfa_pkg::link_t                      ram_wdata,
	output logic                                 ram_re,
	output logic [slfa_pkg::SLOT_W-1:0]          ram_raddr,
	input  wire slfa_pkg::link_t                 ram_rdata
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_FILL = 5'b00010,
		S_READ = 5'b00100,
		S_POP  = 5'b01000,
		S_HOLD = 5'b10000
	} state_t;

	localparam logic [slfa_pkg::LIVE_W-1:0] LIVE_MAX =
		slfa_pkg::LIVE_W'(slfa_pkg::SLOT_SPACE);
	localparam logic [slfa_pkg::OBJ_W-1:0] OBJ_LO = slfa_pkg::OBJ_W'(slfa_pkg::MIN_OBJ);
	localparam logic [slfa_pkg::OBJ_W-1:0] OBJ_HI = slfa_pkg::OBJ_W'(slfa_pkg::MAX_OBJ);

	state_t                              state_q, state_d;
	slfa_pkg::op_t                       op_q, op_d;
	logic [slfa_pkg::SLOT_W-1:0]         head_q, head_d;
	logic                                nonempty_q, nonempty_d;
	logic [slfa_pkg::LIVE_W-1:0]         live_q, live_d;
	logic [slfa_pkg::SLAB_CNT_W-1:0]     slabs_q, slabs_d;
	logic [slfa_pkg::SLOT_W-1:0]         fill_ptr_q, fill_ptr_d;
	logic [slfa_pkg::SLOT_W-1:0]         fill_lo_q, fill_lo_d;
	logic [slfa_pkg::SLOT_W-1:0]         fill_end_q, fill_end_d;
	logic [slfa_pkg::OFS_W-1:0]          prod_q;
	slfa_pkg::result_t                   hold_q, res_c;
	logic                                finish;
	logic [slfa_pkg::OBJ_W-1:0]          obj_eff;
	logic [slfa_pkg::CAP_W-1:0]          cap_now, cap_next;
	logic [slfa_pkg::SLOT_W-1:0]         slab_base;

	always_comb begin
		if (obj_bytes < OBJ_LO) begin
			obj_eff = OBJ_LO;
		end else if (obj_bytes > OBJ_HI) begin
			obj_eff = OBJ_HI;
		end else begin
			obj_eff = obj_bytes;
		end
	end

	assign cap_now   = slfa_pkg::CAP_W'(slabs_q * slfa_pkg::SLAB_SLOTS);
	assign cap_next  = slfa_pkg::CAP_W'(slabs_d * slfa_pkg::SLAB_SLOTS);
	assign slab_base = slfa_pkg::SLOT_W'(cap_now);
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		head_d     = head_q;
		nonempty_d = nonempty_q;
		live_d     = live_q;
		slabs_d    = slabs_q;
		fill_ptr_d = fill_ptr_q;
		fill_lo_d  = fill_lo_q;
		fill_end_d = fill_end_q;
		finish     = 1'b0;
		res_c      = '0;
		res_c.status = slfa_pkg::ST_OK;
		ram_we     = 1'b0;
		ram_waddr  = fill_ptr_q;
		ram_wdata  = '{last: (fill_ptr_q == fill_lo_q), link: fill_ptr_q - 1'b1};
		ram_re     = 1'b0;
		ram_raddr  = head_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d = slfa_pkg::op_t'(operation);
					unique case (slfa_pkg::op_t'(operation))
						slfa_pkg::OP_ALLOC: begin
							if (nonempty_q) begin
								ram_re  = 1'b1;
								state_d = S_POP;
							end else if (slabs_q <
									slfa_pkg::SLAB_CNT_W'(slfa_pkg::USABLE_SLABS)) begin
								// new slab chains downward so its top slot is handed out first
								fill_ptr_d = slab_base;
								fill_lo_d  = slab_base;
								fill_end_d = slab_base +
									slfa_pkg::SLOT_W'(slfa_pkg::SLAB_SLOTS - 1);
								slabs_d    = slabs_q + 1'b1;
								state_d    = S_FILL;
							end else begin
								res_c.status = slfa_pkg::ST_OOM;
								finish       = 1'b1;
							end
						end
						slfa_pkg::OP_FREE: begin
							if (slfa_pkg::CAP_W'(slot) >= cap_now) begin
								res_c.status = slfa_pkg::ST_RANGE;
							end else begin
								ram_we     = 1'b1;
								ram_waddr  = slot;
								ram_wdata  = '{last: !nonempty_q, link: head_q};
								head_d     = slot;
								nonempty_d = 1'b1;
								if (live_q != '0) begin
									live_d = live_q - 1'b1;
								end
							end
							finish = 1'b1;
						end
						slfa_pkg::OP_RESET: begin
							live_d     = '0;
							nonempty_d = 1'b0;
							head_d     = '0;
							if (slabs_q != '0) begin
								fill_ptr_d = '0;
								fill_lo_d  = '0;
								fill_end_d = slfa_pkg::SLOT_W'(cap_now - 1'b1);
								state_d    = S_FILL;
							end else begin
								finish = 1'b1;
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			S_FILL: begin
				ram_we = 1'b1;
				if (fill_ptr_q == fill_end_q) begin
					head_d     = fill_end_q;
					nonempty_d = 1'b1;
					if (op_q == slfa_pkg::OP_ALLOC) begin
						state_d = S_READ;
					end else begin
						finish = 1'b1;
					end
				end else begin
					fill_ptr_d = fill_ptr_q + 1'b1;
				end
			end
			S_READ: begin
				ram_re  = 1'b1;
				state_d = S_POP;
			end
			S_POP: begin
				res_c.granted = head_q;
				res_c.offset  = prod_q;
				head_d        = ram_rdata.link;
				nonempty_d    = !ram_rdata.last;
				if (live_q < LIVE_MAX) begin
					live_d = live_q + 1'b1;
				end
				finish = 1'b1;
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_c.live = live_d;
		res_c.cap  = cap_next;

		if (finish) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end
	end

	assign done = (finish || (state_q == S_HOLD)) && out_free;
	assign res  = (state_q == S_HOLD) ? hold_q : res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= slfa_pkg::OP_NONE;
			head_q     <= '0;
			nonempty_q <= 1'b0;
			live_q     <= '0;
			slabs_q    <= '0;
		end else begin
			state_q    <= state_d;
			op_q       <= op_d;
			head_q     <= head_d;
			nonempty_q <= nonempty_d;
			live_q     <= live_d;
			slabs_q    <= slabs_d;
		end
	end

	// head is stable between the read issue and the pop, so the product is ready in time
	always_ff @(posedge clk) begin
		fill_ptr_q <= fill_ptr_d;
		fill_lo_q  <= fill_lo_d;
		fill_end_q <= fill_end_d;
		prod_q     <= slfa_pkg::OFS_W'(head_q) * slfa_pkg::OFS_W'(obj_eff);
		if (finish && !out_free) begin
			hold_q <= res_c;
		end
	end

endmodule

`default_nettype wire

// ----- design/slab_free_list_allocator_unit.sv -----
// From accept to output register: free, unused code and out of memory finish in S_IDLE;
// allocate from the list reads the link memory, then pops in S_POP; allocate that adds a slab
// links it in S_FILL, then S_READ, S_POP; reset relinks slabs in use (one link write a cycle).
// Throughput: one free every cycle while the output stage has room; allocates do not overlap.
// arst_n clears head, counts, slab count and object size (8); link memory is not cleared.
// slab_free_list_allocator_unit: top level; object size register, output stage, assertions
// depends on slfa_pkg, slfa_ctrl, slfa_link_ram
`timescale 1ns / 1ps
`default_nettype none

module slab_free_list_allocator_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [slfa_pkg::OBJ_W-1:0]    object_bytes,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    operation,
	input  wire logic [slfa_pkg::SLOT_W-1:0]   slot,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [slfa_pkg::SLOT_W-1:0]        granted_slot,
	output logic [slfa_pkg::OFS_W-1:0]         byte_offset,
	output logic [1:0]                         status,
	output logic [slfa_pkg::LIVE_W-1:0]        live_count,
	output logic [slfa_pkg::CAP_W-1:0]         capacity
);

	logic [slfa_pkg::OBJ_W-1:0]  obj_bytes_q;
	logic                        out_valid_q;
	slfa_pkg::result_t           out_res_q;
	logic                        out_free;
	logic                        ctrl_done;
	slfa_pkg::result_t           ctrl_res;
	logic                        ram_we;
	logic [slfa_pkg::SLOT_W-1:0] ram_waddr;
	slfa_pkg::link_t             ram_wdata;
	logic                        ram_re;
	logic [slfa_pkg::SLOT_W-1:0] ram_raddr;
	logic [$bits(slfa_pkg::link_t)-1:0] ram_rdata;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_bytes_q <= slfa_pkg::OBJ_W'(slfa_pkg::MIN_OBJ);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				obj_bytes_q <= object_bytes;
			end
			if (ctrl_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_done) begin
			out_res_q <= ctrl_res;
		end
	end

	slfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.slot      (slot),
		.obj_bytes (obj_bytes_q),
		.out_free  (out_free),
		.done      (ctrl_done),
		.res       (ctrl_res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (slfa_pkg::link_t'(ram_rdata))
	);

	slfa_link_ram #(
		.DEPTH (slfa_pkg::SLOT_SPACE),
		.WIDTH ($bits(slfa_pkg::link_t))
	) u_link_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign out_valid    = out_valid_q;
	assign granted_slot = out_res_q.granted;
	assign byte_offset  = out_res_q.offset;
	assign status       = out_res_q.status;
	assign live_count   = out_res_q.live;
	assign capacity     = out_res_q.cap;

	// a result is only handed over when the output stage can take it
	a_done_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_done |-> out_free)
		else $error("result handed over with output stage full");

	a_cap_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_res_q.cap <= slfa_pkg::CAP_W'(slfa_pkg::MAX_CAP)))
		else $error("capacity beyond usable slabs");

	// out of memory is only reported once every usable slab is in use
	a_oom_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_res_q.status == slfa_pkg::ST_OOM))
		|-> (out_res_q.cap == slfa_pkg::CAP_W'(slfa_pkg::MAX_CAP)))
		else $error("out of memory with slabs left");

	// no new transaction is taken while a finished result is still held back
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && $past(ctrl_done) && in_ready) |=> !ctrl_done || out_free)
		else $error("result overrun in output stage");

endmodule

`default_nettype wire
